// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: design/rfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

   typedef enum logic [3:0] {
      PH_SYNC0   = 4'd0,
      PH_SYNC1   = 4'd1,
      PH_LEN_LO  = 4'd2,
      PH_LEN_HI  = 4'd3,
      PH_CMD     = 4'd4,
      PH_SEQ     = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CRC_LO  = 4'd7,
      PH_CRC_HI  = 4'd8
   } phase_type;

   localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
   localparam logic [1:0] KIND_GOOD       = 2'd1;
   localparam logic [1:0] KIND_BAD_CRC    = 2'd2;
   localparam logic [1:0] KIND_BAD_LENGTH = 2'd3;

   localparam logic REG_SYNC_FIRST  = 1'b0;
   localparam logic REG_SYNC_SECOND = 1'b1;

   localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'h1021;

   // CRC16-CCITT, MSB first, one byte.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: design/rx_frame_parser_crc16_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   rx_byte, line_error
// rsp_      out        rsp_valid/rsp_ready   kind, data_byte, byte_index, command,
//                                            sequence_res, frame_length
// csr_      in         APB, pready always 1  sync_first @0x0, sync_second @0x4
//
// One item per cycle sustained while rsp_ready stays high; a request passes the
// input register, the parse step and the result register on its way to rsp.
// A held result stalls only the input register; req_ready drops only when both
// the input register and the result register are full and rsp_ready is low.
// Reset is synchronous: parser back to hunting the first sync byte, sync
// registers to 0xAA/0x55, both pipeline registers empty.

module rx_frame_parser_crc16_unit #(
   parameter int MAX_PAYLOAD = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_line_error,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [7:0]       rsp_byte_index,
   output logic [7:0]       rsp_command,
   output logic [7:0]       rsp_sequence_res,
   output logic [15:0]      rsp_frame_length,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int PosW = $clog2(MAX_PAYLOAD + 1);

   logic             s1_valid_ff, s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic             s1_err_ff;

   rfp_pkg::phase_type phase_ff, phase_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       seq_ff, seq_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [7:0]       sync_first_ff, sync_second_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [7:0]       rsp_index_ff, rsp_index_in;
   logic [7:0]       rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]       rsp_seq_ff, rsp_seq_in;
   logic [15:0]      rsp_len_ff, rsp_len_in;

   logic             advance, take, emit, csr_write;
   logic [15:0]      len_full;
   logic [15:0]      got_crc;
   logic [PosW-1:0]  pos_inc;

   assign advance     = !rsp_valid_ff || rsp_ready;
   assign take        = s1_valid_ff && advance;
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (take ? 1'b0 : s1_valid_ff);

   assign len_full = {s1_byte_ff, len_ff[7:0]};
   assign got_crc  = {s1_byte_ff, crc_lo_ff};
   assign pos_inc  = pos_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      cmd_in       = cmd_ff;
      seq_in       = seq_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      crc_lo_in    = crc_lo_ff;
      emit         = 1'b0;
      rsp_kind_in  = rfp_pkg::KIND_PAYLOAD;
      rsp_data_in  = 8'h00;
      rsp_index_in = 8'h00;
      rsp_cmd_in   = cmd_ff;
      rsp_seq_in   = seq_ff;
      rsp_len_in   = len_ff;
      if (take) begin
         if (s1_err_ff) begin
            phase_in = rfp_pkg::PH_SYNC0;
         end else begin
            case (phase_ff)
               rfp_pkg::PH_SYNC0: begin
                  if (s1_byte_ff == sync_first_ff) phase_in = rfp_pkg::PH_SYNC1;
               end
               rfp_pkg::PH_SYNC1: begin
                  if (s1_byte_ff == sync_second_ff) begin
                     phase_in = rfp_pkg::PH_LEN_LO;
                  end else if (s1_byte_ff != sync_first_ff) begin
                     phase_in = rfp_pkg::PH_SYNC0;
                  end
               end
               rfp_pkg::PH_LEN_LO: begin
                  len_in   = {8'h00, s1_byte_ff};
                  phase_in = rfp_pkg::PH_LEN_HI;
               end
               rfp_pkg::PH_LEN_HI: begin
                  len_in = len_full;
                  if (len_full > 16'(MAX_PAYLOAD)) begin
                     emit        = 1'b1;
                     rsp_kind_in = rfp_pkg::KIND_BAD_LENGTH;
                     rsp_cmd_in  = 8'h00;
                     rsp_seq_in  = 8'h00;
                     rsp_len_in  = len_full;
                     phase_in    = rfp_pkg::PH_SYNC0;
                  end else begin
                     phase_in = rfp_pkg::PH_CMD;
                  end
               end
               rfp_pkg::PH_CMD: begin
                  cmd_in   = s1_byte_ff;
                  crc_in   = rfp_pkg::crc_step(rfp_pkg::CRC_INIT, s1_byte_ff);
                  phase_in = rfp_pkg::PH_SEQ;
               end
               rfp_pkg::PH_SEQ: begin
                  seq_in   = s1_byte_ff;
                  crc_in   = rfp_pkg::crc_step(crc_ff, s1_byte_ff);
                  pos_in   = '0;
                  phase_in = (len_ff != 16'h0000) ? rfp_pkg::PH_PAYLOAD : rfp_pkg::PH_CRC_LO;
               end
               rfp_pkg::PH_PAYLOAD: begin
                  emit         = 1'b1;
                  rsp_kind_in  = rfp_pkg::KIND_PAYLOAD;
                  rsp_data_in  = s1_byte_ff;
                  rsp_index_in = 8'(pos_ff);
                  crc_in       = rfp_pkg::crc_step(crc_ff, s1_byte_ff);
                  pos_in       = pos_inc;
                  if (16'(pos_inc) >= len_ff) phase_in = rfp_pkg::PH_CRC_LO;
               end
               rfp_pkg::PH_CRC_LO: begin
                  crc_lo_in = s1_byte_ff;
                  phase_in  = rfp_pkg::PH_CRC_HI;
               end
               rfp_pkg::PH_CRC_HI: begin
                  emit        = 1'b1;
                  rsp_kind_in = (got_crc == crc_ff) ? rfp_pkg::KIND_GOOD : rfp_pkg::KIND_BAD_CRC;
                  phase_in    = rfp_pkg::PH_SYNC0;
               end
               default: begin
                  phase_in = rfp_pkg::PH_SYNC0;
               end
            endcase
         end
      end
   end

   assign rsp_valid_in = advance ? (take && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= rfp_pkg::PH_SYNC0;
         len_ff       <= 16'h0000;
         cmd_ff       <= 8'h00;
         seq_ff       <= 8'h00;
         pos_ff       <= '0;
         crc_ff       <= rfp_pkg::CRC_INIT;
         crc_lo_ff    <= 8'h00;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         cmd_ff       <= cmd_in;
         seq_ff       <= seq_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         crc_lo_ff    <= crc_lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_rx_byte;
         s1_err_ff  <= req_line_error;
      end
      if (take && emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_index_ff <= rsp_index_in;
         rsp_cmd_ff   <= rsp_cmd_in;
         rsp_seq_ff   <= rsp_seq_in;
         rsp_len_ff   <= rsp_len_in;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= rfp_pkg::SYNC_FIRST_RESET;
         sync_second_ff <= rfp_pkg::SYNC_SECOND_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == rfp_pkg::REG_SYNC_FIRST) begin
            sync_first_ff <= csr_pwdata[7:0];
         end else begin
            sync_second_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == rfp_pkg::REG_SYNC_SECOND) ?
                       {24'h000000, sync_second_ff} : {24'h000000, sync_first_ff};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_command      = rsp_cmd_ff;
   assign rsp_sequence_res = rsp_seq_ff;
   assign rsp_frame_length = rsp_len_ff;

endmodule

`default_nettype wire

// File: design/rfp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rfp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic [7:0]  rsp_byte_index,
   input wire logic [7:0]  rsp_command,
   input wire logic [7:0]  rsp_sequence_res,
   input wire logic [15:0] rsp_frame_length,
   input wire logic        csr_pready
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_byte_index) && $stable(rsp_frame_length))
   `ASSERT_IMPLIES(a_stall_only_on_full_out, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `ASSERT_IMPLIES(a_status_no_data, clock, reset, rsp_valid && rsp_kind != rfp_pkg::KIND_PAYLOAD, rsp_data_byte == 8'h00 && rsp_byte_index == 8'h00)
   `ASSERT_IMPLIES(a_bad_len_no_hdr, clock, reset, rsp_valid && rsp_kind == rfp_pkg::KIND_BAD_LENGTH, rsp_command == 8'h00 && rsp_sequence_res == 8'h00)
   `ASSERT_IMPLIES(a_pready_high, clock, reset, req_valid || !req_valid, csr_pready)

endmodule

bind rx_frame_parser_crc16_unit rfp_checker u_rfp_checker (.*);

`default_nettype wire
